/* rtl/lsfs_pkg.sv */
// Shared types, constants and helpers for the LED strip frame serializer.
// No dependencies; every other file in rtl/ imports this package.
package lsfs_pkg;

  localparam int LED_COUNT = 64;
  localparam int LED_AW    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FILL  = 2'd1,
    OP_SEND  = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  localparam logic [2:0] CFG_ONE_HIGH  = 3'd0;
  localparam logic [2:0] CFG_ONE_LOW   = 3'd1;
  localparam logic [2:0] CFG_ZERO_HIGH = 3'd2;
  localparam logic [2:0] CFG_ZERO_LOW  = 3'd3;
  localparam logic [2:0] CFG_LATCH_GAP = 3'd4;

  typedef struct packed {
    logic [7:0]  one_high_ticks;
    logic [7:0]  one_low_ticks;
    logic [7:0]  zero_high_ticks;
    logic [7:0]  zero_low_ticks;
    logic [15:0] latch_gap_ticks;
  } cfg_t;

  // request to the color store; color is {green, red, blue}
  typedef struct packed {
    logic              wr_en;
    logic              fill_en;
    logic              rd_en;
    logic [LED_AW-1:0] addr;
    logic [23:0]       color;
  } mem_cmd_t;

  typedef struct packed {
    logic line;
    logic busy;
    logic done;
  } res_t;

  function automatic logic [15:0] at_least_one(logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic [LED_AW-1:0] clamp_index(logic [7:0] idx);
    if ({1'b0, idx} >= 9'(LED_COUNT)) begin
      return LED_AW'(LED_COUNT - 1);
    end
    return LED_AW'(idx);
  endfunction

endpackage

/* rtl/led_strip_frame_serializer_unit.sv */
// LED strip frame serializer: top level with handshake, timing registers
// and output register. Instantiates lsfs_engine and lsfs_color_mem.
// Depends on lsfs_pkg.
//
// Usage: items enter on in_valid/in_stall (op, led_index, red, green, blue).
// Write sets one LED, fill sets all LEDs, send starts a frame of LEDs 0 to
// led_index, tick advances the waveform one time unit. Every item yields one
// transaction on out_valid/out_stall carrying data_line, busy_res, frame_done.
// The result sits in the output register the cycle after the item is taken.
// One item is taken per cycle while in_stall is low; a send that starts a
// frame raises in_stall while LED 0 is read from the color RAM. Later LEDs
// are prefetched during the current LED, so ticks run at one per cycle for
// the whole frame while the output is not stalled. While the output register
// holds an untaken transaction and out_stall is high, in_stall is high and
// nothing moves. Reset (synchronous) clears the color store to black at once
// through per-LED valid bits, loads the timing registers with their defaults
// and idles the line. The user must write the timing registers through
// cfg_wr_en/cfg_index/cfg_data while the block is idle; it is not enforced.
module led_strip_frame_serializer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  led_index,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        data_line,
  output logic        busy_res,
  output logic        frame_done
);
  import lsfs_pkg::*;

  cfg_t     cfg;
  mem_cmd_t mem_cmd;
  res_t     res;
  logic     loading;
  logic     item_go;
  logic [23:0] rd_color;

  assign in_stall = loading | (out_valid & out_stall);
  assign item_go  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.one_high_ticks  <= 8'd5;
      cfg.one_low_ticks   <= 8'd7;
      cfg.zero_high_ticks <= 8'd4;
      cfg.zero_low_ticks  <= 8'd13;
      cfg.latch_gap_ticks <= 16'd816;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ONE_HIGH:  cfg.one_high_ticks  <= cfg_data[7:0];
        CFG_ONE_LOW:   cfg.one_low_ticks   <= cfg_data[7:0];
        CFG_ZERO_HIGH: cfg.zero_high_ticks <= cfg_data[7:0];
        CFG_ZERO_LOW:  cfg.zero_low_ticks  <= cfg_data[7:0];
        CFG_LATCH_GAP: cfg.latch_gap_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  lsfs_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .item_go    (item_go),
    .item_op    (op_t'(op)),
    .item_index (led_index),
    .item_color ({green, red, blue}),
    .cfg        (cfg),
    .rd_color   (rd_color),
    .mem_cmd    (mem_cmd),
    .res        (res),
    .loading    (loading)
  );

  lsfs_color_mem u_color_mem (
    .clk      (clk),
    .rst      (rst),
    .cmd      (mem_cmd),
    .rd_color (rd_color)
  );

  // output register: load on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= item_go | (out_valid & out_stall);
    end
    if (item_go) begin
      data_line  <= res.line;
      busy_res   <= res.busy;
      frame_done <= res.done;
    end
  end

endmodule

/* rtl/lsfs_color_mem.sv */
// Per-LED color store: synchronous RAM with registered read.
// Per-entry valid bits plus a fill color give reset and fill without walking the entries.
// Depends on lsfs_pkg.
module lsfs_color_mem (
  input  logic               clk,
  input  logic               rst,
  input  lsfs_pkg::mem_cmd_t cmd,
  output logic [23:0]        rd_color
);
  import lsfs_pkg::*;

  logic [23:0]          mem [0:LED_COUNT-1];
  logic [LED_COUNT-1:0] valid;
  logic [23:0]          fill_color;
  logic [23:0]          rd_data;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.addr] <= cmd.color;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      fill_color <= '0;
      rd_valid   <= 1'b0;
    end else begin
      // a fill drops every written entry back to the fill color
      if (cmd.fill_en) begin
        valid      <= '0;
        fill_color <= cmd.color;
      end else if (cmd.wr_en) begin
        valid[cmd.addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_valid <= valid[cmd.addr];
      end
    end
  end

  assign rd_color = rd_valid ? rd_data : fill_color;

endmodule

/* rtl/lsfs_engine.sv */
// Waveform sequencer: decodes commands, walks LEDs, bytes and bits, and
// times each high/low phase. Prefetches the next LED from lsfs_color_mem.
// Depends on lsfs_pkg.
module lsfs_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_go,
  input  lsfs_pkg::op_t      item_op,
  input  logic [7:0]         item_index,
  input  logic [23:0]        item_color,
  input  lsfs_pkg::cfg_t     cfg,
  input  logic [23:0]        rd_color,
  output lsfs_pkg::mem_cmd_t mem_cmd,
  output lsfs_pkg::res_t     res,
  output logic               loading
);
  import lsfs_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LOAD,
    PH_HIGH,
    PH_LOW,
    PH_LATCH
  } phase_t;

  phase_t            phase, phase_next;
  logic [15:0]       phase_count, phase_count_next;
  logic [LED_AW-1:0] send_led, send_led_next;
  logic [LED_AW-1:0] last_led, last_led_next;
  logic [1:0]        byte_slot, byte_slot_next;
  logic [2:0]        bit_slot, bit_slot_next;
  logic [7:0]        shift_byte, shift_byte_next;
  logic [23:0]       pixel, pixel_next;

  function automatic logic [15:0] high_len(cfg_t c, logic msb);
    return at_least_one({8'd0, msb ? c.one_high_ticks : c.zero_high_ticks});
  endfunction

  function automatic logic [15:0] low_len(cfg_t c, logic msb);
    return at_least_one({8'd0, msb ? c.one_low_ticks : c.zero_low_ticks});
  endfunction

  function automatic logic [7:0] byte_of(logic [23:0] px, logic [1:0] slot);
    logic [7:0] b;
    case (slot)
      2'd0:    b = px[23:16];
      2'd1:    b = px[15:8];
      default: b = px[7:0];
    endcase
    return b;
  endfunction

  always_comb begin
    logic [7:0]        shifted;
    logic [LED_AW-1:0] nxt_led;

    phase_next       = phase;
    phase_count_next = phase_count;
    send_led_next    = send_led;
    last_led_next    = last_led;
    byte_slot_next   = byte_slot;
    bit_slot_next    = bit_slot;
    shift_byte_next  = shift_byte;
    pixel_next       = pixel;
    shifted          = {shift_byte[6:0], 1'b0};
    nxt_led          = send_led + LED_AW'(1);

    mem_cmd       = '0;
    mem_cmd.color = item_color;
    mem_cmd.addr  = clamp_index(item_index);

    res.line = (phase == PH_HIGH);
    res.busy = (phase != PH_IDLE);
    res.done = 1'b0;

    if (phase == PH_LOAD) begin
      // LED 0 arrives from the store; prefetch LED 1 if the frame has one
      pixel_next       = rd_color;
      shift_byte_next  = rd_color[23:16];
      phase_next       = PH_HIGH;
      phase_count_next = high_len(cfg, rd_color[23]);
      if (send_led != last_led) begin
        mem_cmd.rd_en = 1'b1;
        mem_cmd.addr  = nxt_led;
      end
    end else if (item_go) begin
      if (item_op == OP_TICK) begin
        if (phase != PH_IDLE) begin
          if (phase_count > 16'd1) begin
            phase_count_next = phase_count - 16'd1;
          end else begin
            unique case (phase)
              PH_HIGH: begin
                phase_next       = PH_LOW;
                phase_count_next = low_len(cfg, shift_byte[7]);
              end
              PH_LOW: begin
                shift_byte_next = shifted;
                if (bit_slot != 3'd7) begin
                  bit_slot_next    = bit_slot + 3'd1;
                  phase_next       = PH_HIGH;
                  phase_count_next = high_len(cfg, shifted[7]);
                end else if (byte_slot != 2'd2) begin
                  bit_slot_next    = 3'd0;
                  byte_slot_next   = byte_slot + 2'd1;
                  shift_byte_next  = byte_of(pixel, byte_slot + 2'd1);
                  phase_next       = PH_HIGH;
                  phase_count_next =
                    high_len(cfg, byte_of(pixel, byte_slot + 2'd1) >> 7 != 8'd0);
                end else if (send_led >= last_led) begin
                  bit_slot_next    = 3'd0;
                  byte_slot_next   = 2'd0;
                  phase_next       = PH_LATCH;
                  phase_count_next = at_least_one(cfg.latch_gap_ticks);
                end else begin
                  // advance to the prefetched LED and fetch the one after it, if the frame has one
                  bit_slot_next    = 3'd0;
                  byte_slot_next   = 2'd0;
                  send_led_next    = nxt_led;
                  pixel_next       = rd_color;
                  shift_byte_next  = rd_color[23:16];
                  phase_next       = PH_HIGH;
                  phase_count_next = high_len(cfg, rd_color[23]);
                  if (nxt_led != last_led) begin
                    mem_cmd.rd_en = 1'b1;
                    mem_cmd.addr  = nxt_led + LED_AW'(1);
                  end
                end
              end
              PH_LATCH: begin
                phase_next       = PH_IDLE;
                phase_count_next = 16'd0;
                res.done         = 1'b1;
              end
              default: ;
            endcase
          end
        end
      end else if (phase == PH_IDLE) begin
        unique case (item_op)
          OP_WRITE: mem_cmd.wr_en = 1'b1;
          OP_FILL:  mem_cmd.fill_en = 1'b1;
          OP_SEND: begin
            last_led_next  = clamp_index(item_index);
            send_led_next  = '0;
            byte_slot_next = 2'd0;
            bit_slot_next  = 3'd0;
            mem_cmd.rd_en  = 1'b1;
            mem_cmd.addr   = '0;
            phase_next     = PH_LOAD;
            res.line       = 1'b1;
            res.busy       = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      phase_count <= '0;
      send_led    <= '0;
      last_led    <= '0;
      byte_slot   <= '0;
      bit_slot    <= '0;
    end else begin
      phase       <= phase_next;
      phase_count <= phase_count_next;
      send_led    <= send_led_next;
      last_led    <= last_led_next;
      byte_slot   <= byte_slot_next;
      bit_slot    <= bit_slot_next;
    end
    shift_byte <= shift_byte_next;
    pixel      <= pixel_next;
  end

  assign loading = (phase == PH_LOAD);

  a_no_item_in_load: assert property (@(posedge clk) disable iff (rst)
    item_go |-> phase != PH_LOAD)
    else $error("item accepted while the first LED is loading");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LOAD |=> phase == PH_HIGH)
    else $error("load phase did not hand over to a high phase");

  a_store_idle_only: assert property (@(posedge clk) disable iff (rst)
    (mem_cmd.wr_en || mem_cmd.fill_en) |-> phase == PH_IDLE && !mem_cmd.rd_en)
    else $error("color store modified during a frame");

  a_led_in_range: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE |-> send_led <= last_led)
    else $error("sending LED past the end of the frame");

  a_count_live: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HIGH || phase == PH_LOW || phase == PH_LATCH) |-> phase_count != 16'd0)
    else $error("timed phase with an empty tick count");

endmodule

/* tb/led_strip_frame_serializer_unit_tb.sv */
// Self-checking testbench for led_strip_frame_serializer_unit: drives write, fill,
// send and tick transactions and checks every pin result against a cycle-free model.
// Depends on lsfs_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module led_strip_frame_serializer_unit_tb;
  import lsfs_pkg::*;

  localparam int RAND_ITEMS = 150;
  localparam logic [2:0] CFG_SPARE = 3'd7;

  typedef enum logic [1:0] {LS_IDLE, LS_HIGH, LS_LOW, LS_LATCH} line_state_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = 2'd0;
  logic [7:0]  led_index = 8'd0;
  logic [7:0]  red = 8'd0;
  logic [7:0]  green = 8'd0;
  logic [7:0]  blue = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        data_line;
  logic        busy_res;
  logic        frame_done;

  led_strip_frame_serializer_unit u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .led_index(led_index),
    .red(red),
    .green(green),
    .blue(blue),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .data_line(data_line),
    .busy_res(busy_res),
    .frame_done(frame_done)
  );

  // pin model state
  logic [23:0] led_grb [LED_COUNT];
  cfg_t        timing;
  line_state_t pin_state;
  logic [15:0] ticks_left;
  logic [7:0]  cur_led;
  logic [7:0]  end_led;
  logic [7:0]  out_byte;
  int          byte_no;
  int          bit_no;

  res_t levels_due[$];
  int   mismatch_count = 0;
  int   results_seen = 0;
  int   items_sent = 0;
  int   src_idle_pct = 0;
  int   snk_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400_000;
    $display("led_strip_frame_serializer_unit regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < snk_idle_pct);
  end

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic void reset_model();
    foreach (led_grb[i]) led_grb[i] = 24'd0;
    timing.one_high_ticks  = 8'd5;
    timing.one_low_ticks   = 8'd7;
    timing.zero_high_ticks = 8'd4;
    timing.zero_low_ticks  = 8'd13;
    timing.latch_gap_ticks = 16'd816;
    pin_state  = LS_IDLE;
    ticks_left = 16'd0;
    cur_led    = 8'd0;
    end_led    = 8'd0;
    out_byte   = 8'd0;
    byte_no    = 0;
    bit_no     = 0;
  endfunction

  function automatic logic [15:0] phase_len(logic [15:0] t);
    return (t == 16'd0) ? 16'd1 : t;
  endfunction

  function automatic void load_color_byte();
    logic [23:0] grb;
    grb = led_grb[cur_led];
    case (byte_no)
      0: out_byte = grb[23:16];
      1: out_byte = grb[15:8];
      default: out_byte = grb[7:0];
    endcase
  endfunction

  function automatic void start_high();
    pin_state  = LS_HIGH;
    ticks_left = phase_len(out_byte[7] ? 16'(timing.one_high_ticks)
                                       : 16'(timing.zero_high_ticks));
  endfunction

  function automatic void advance_bit();
    out_byte = out_byte << 1;
    bit_no++;
    if (bit_no < 8) begin
      start_high();
      return;
    end
    bit_no = 0;
    byte_no++;
    if (byte_no >= 3) begin
      byte_no = 0;
      // last LED done: hold the line low for the latch gap
      if (cur_led >= end_led) begin
        pin_state  = LS_LATCH;
        ticks_left = phase_len(timing.latch_gap_ticks);
        return;
      end
      cur_led++;
    end
    load_color_byte();
    start_high();
  endfunction

  function automatic res_t predict_pin(op_t o, logic [7:0] idx, logic [7:0] r,
                                       logic [7:0] g, logic [7:0] b);
    res_t res;
    logic [7:0] slot;
    res  = '0;
    slot = (idx >= LED_COUNT) ? 8'(LED_COUNT - 1) : idx;
    if (o == OP_TICK) begin
      res.line = (pin_state == LS_HIGH);
      res.busy = (pin_state != LS_IDLE);
      if (pin_state != LS_IDLE) begin
        if (ticks_left > 16'd1) begin
          ticks_left--;
        end else begin
          case (pin_state)
            LS_HIGH: begin
              pin_state  = LS_LOW;
              ticks_left = phase_len(out_byte[7] ? 16'(timing.one_low_ticks)
                                                 : 16'(timing.zero_low_ticks));
            end
            LS_LOW: advance_bit();
            default: begin
              pin_state  = LS_IDLE;
              ticks_left = 16'd0;
              res.done   = 1'b1;
            end
          endcase
        end
      end
    end else begin
      // drop commands while a frame is running
      if (pin_state == LS_IDLE) begin
        case (o)
          OP_WRITE: led_grb[slot] = {g, r, b};
          OP_FILL: foreach (led_grb[i]) led_grb[i] = {g, r, b};
          default: begin
            end_led = slot;
            cur_led = 8'd0;
            byte_no = 0;
            bit_no  = 0;
            load_color_byte();
            start_high();
          end
        endcase
      end
      res.line = (pin_state == LS_HIGH);
      res.busy = (pin_state != LS_IDLE);
    end
    return res;
  endfunction

  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (levels_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        want = levels_due.pop_front();
        if (data_line !== want.line)
          report_mismatch($sformatf("result %0d data_line %b, want %b",
                                    results_seen, data_line, want.line));
        if (busy_res !== want.busy)
          report_mismatch($sformatf("result %0d busy_res %b, want %b",
                                    results_seen, busy_res, want.busy));
        if (frame_done !== want.done)
          report_mismatch($sformatf("result %0d frame_done %b, want %b",
                                    results_seen, frame_done, want.done));
      end
    end
  end

  task automatic set_idling(int src_pct, int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
  endtask

  task automatic put_item(op_t o, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                          logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= o;
    led_index <= idx;
    red       <= r;
    green     <= g;
    blue      <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    levels_due.push_back(predict_pin(o, idx, r, g, b));
    items_sent++;
  endtask

  task automatic put_tick();
    put_item(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic finish_frame();
    while (pin_state != LS_IDLE) put_tick();
  endtask

  // wait until every result is back and the block has settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ONE_HIGH:  timing.one_high_ticks  = val[7:0];
      CFG_ONE_LOW:   timing.one_low_ticks   = val[7:0];
      CFG_ZERO_HIGH: timing.zero_high_ticks = val[7:0];
      CFG_ZERO_LOW:  timing.zero_low_ticks  = val[7:0];
      CFG_LATCH_GAP: timing.latch_gap_ticks = val;
      default: ;
    endcase
  endtask

  task automatic set_all_timing(logic [15:0] bit_val, logic [15:0] gap_val);
    wait_idle();
    set_reg(CFG_ONE_HIGH, bit_val);
    set_reg(CFG_ONE_LOW, bit_val);
    set_reg(CFG_ZERO_HIGH, bit_val);
    set_reg(CFG_ZERO_LOW, bit_val);
    set_reg(CFG_LATCH_GAP, gap_val);
  endtask

  // short bit timings keep frames brief; upper data bits must be ignored
  task automatic randomize_timing();
    logic [7:0] v;
    wait_idle();
    for (int i = CFG_ONE_HIGH; i <= CFG_ZERO_LOW; i++) begin
      v = ($urandom_range(4) == 0) ? 8'($urandom_range(3, 2)) : 8'd1;
      if ($urandom_range(9) == 0) v = 8'd0;
      set_reg(3'(i), {8'($urandom), v});
    end
    set_reg(CFG_LATCH_GAP, ($urandom_range(7) == 0) ? 16'($urandom_range(280, 20))
                                                     : 16'($urandom_range(12)));
    if ($urandom_range(3) == 0) set_reg(CFG_SPARE, 16'($urandom));
  endtask

  task automatic put_random_command();
    logic [7:0] idx;
    int pick;
    idx  = ($urandom_range(15) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    pick = $urandom_range(7);
    if (pick == 0)
      put_item(OP_FILL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    else if (pick == 1)
      put_item(OP_SEND, 8'($urandom_range(1)), 8'($urandom), 8'($urandom), 8'($urandom));
    else
      put_item(OP_WRITE, idx, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic test_directed();
    // shorten the latch gap only; bit timing stays at its reset values
    wait_idle();
    set_reg(CFG_LATCH_GAP, 16'd6);
    put_tick();
    put_item(OP_FILL, 8'd0, 8'hFF, 8'hFF, 8'hFF);
    put_item(OP_FILL, 8'd255, 8'h00, 8'h00, 8'h00);
    put_item(OP_WRITE, 8'd255, 8'h42, 8'h81, 8'h24);
    put_item(OP_WRITE, 8'd64, 8'hFF, 8'h00, 8'hFF);
    put_item(OP_WRITE, 8'd63, 8'h00, 8'hFF, 8'h00);
    put_item(OP_WRITE, 8'd0, 8'h0F, 8'hF0, 8'hA5);
    put_item(OP_WRITE, 8'd1, 8'hFF, 8'h00, 8'h01);
    put_item(OP_SEND, 8'd0, 8'h00, 8'h00, 8'h00);
    // all three must be dropped while the frame runs
    put_item(OP_WRITE, 8'd0, 8'h00, 8'h00, 8'h00);
    put_item(OP_FILL, 8'd0, 8'h55, 8'hAA, 8'h55);
    put_item(OP_SEND, 8'd255, 8'hFF, 8'hFF, 8'hFF);
    repeat (30) put_tick();
    put_item(OP_FILL, 8'd0, 8'h00, 8'h00, 8'h00);
    finish_frame();
    put_tick();
    // distinct one and zero shapes so the stored color shows on the line
    wait_idle();
    set_reg(CFG_ONE_HIGH, 16'd2);
    set_reg(CFG_ONE_LOW, 16'd1);
    set_reg(CFG_ZERO_HIGH, 16'd1);
    set_reg(CFG_ZERO_LOW, 16'd2);
    put_item(OP_SEND, 8'd0, 8'hFF, 8'hFF, 8'hFF);
    finish_frame();
    put_tick();
  endtask

  task automatic test_timing_extremes();
    set_all_timing(16'd1, 16'd1);
    put_item(OP_FILL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    put_item(OP_WRITE, 8'd255, 8'($urandom), 8'($urandom), 8'($urandom));
    put_item(OP_WRITE, 8'd1, 8'($urandom), 8'($urandom), 8'($urandom));
    put_item(OP_SEND, 8'd1, 8'd0, 8'd0, 8'd0);
    finish_frame();

    // zero lengths run as one tick
    set_all_timing(16'd0, 16'd0);
    put_item(OP_SEND, 8'd0, 8'd0, 8'd0, 8'd0);
    finish_frame();

    set_all_timing(16'hFF01, 16'd2);
    set_reg(CFG_SPARE, 16'h0001);
    put_item(OP_WRITE, 8'd0, 8'h3C, 8'hC3, 8'h5A);
    put_item(OP_SEND, 8'd0, 8'd0, 8'd0, 8'd0);
    finish_frame();
  endtask

  task automatic test_random_frames(int quota);
    int start_count;
    start_count = items_sent;
    randomize_timing();
    while (items_sent - start_count < quota) begin
      if ($urandom_range(2) == 0) randomize_timing();
      repeat ($urandom_range(4, 1)) put_random_command();
      if ($urandom_range(5) == 0) put_tick();
      put_item(OP_SEND, ($urandom_range(3) == 0) ? 8'd1 : 8'd0,
               8'($urandom), 8'($urandom), 8'($urandom));
      while (pin_state != LS_IDLE) begin
        if ($urandom_range(24) == 0) put_random_command();
        else put_tick();
      end
      repeat ($urandom_range(2)) put_tick();
    end
  endtask

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(17, 73);
    test_directed();
    test_random_frames(RAND_ITEMS / 3);
    set_idling(73, 17);
    test_random_frames(RAND_ITEMS / 3);
    set_idling(0, 0);
    test_timing_extremes();
    test_random_frames(RAND_ITEMS / 3);

    in_valid <= 1'b0;
    for (int w = 0; w < 20000 && levels_due.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (levels_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", levels_due.size()));
    if (mismatch_count == 0) begin
      $display("led_strip_frame_serializer_unit regression: pass");
    end else begin
      $display("led_strip_frame_serializer_unit regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/lsfs_pkg.sv
rtl/lsfs_color_mem.sv
rtl/lsfs_engine.sv
rtl/led_strip_frame_serializer_unit.sv
tb/led_strip_frame_serializer_unit_tb.sv
